[design/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ansi_ela_pkg.sv]
// types, command codes and constants of the escape line assembler
package ansi_ela_pkg;

  localparam int LEN_W    = 6;
  localparam int MARK_LEN = 10;

  localparam logic [3:0] OP_PUT   = 4'd0;
  localparam logic [3:0] OP_NL    = 4'd1;
  localparam logic [3:0] OP_FLUSH = 4'd2;
  localparam logic [3:0] OP_CR    = 4'd3;
  localparam logic [3:0] OP_BS    = 4'd4;
  localparam logic [3:0] OP_ERASE = 4'd5;
  localparam logic [3:0] OP_RIGHT = 4'd6;
  localparam logic [3:0] OP_LEFT  = 4'd7;
  localparam logic [3:0] OP_COL   = 4'd8;
  localparam logic [3:0] OP_DEL   = 4'd9;
  localparam logic [3:0] OP_INS   = 4'd10;
  localparam logic [3:0] OP_BLANK = 4'd11;

  localparam logic [7:0] CH_ESC = 8'h1b;
  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_char;
    logic       empty_line;
    logic       last_of_line;
    logic [7:0] tag;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  ch;
    logic [15:0] num;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] mark_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = " ";
      4'd1:    c = "[";
      4'd2:    c = "w";
      4'd3:    c = "r";
      4'd4:    c = "a";
      4'd5:    c = "p";
      4'd6:    c = "p";
      4'd7:    c = "e";
      4'd8:    c = "d";
      4'd9:    c = "]";
      default: c = " ";
    endcase
    return c;
  endfunction

endpackage

[design/ansi_ela_front.sv]
// escape parser: turns stream bytes into line editing commands
module ansi_ela_front import ansi_ela_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     push,
  output cmd_t     cmd
);

  localparam logic [2:0] PS_NORMAL  = 3'd0;
  localparam logic [2:0] PS_ESC     = 3'd1;
  localparam logic [2:0] PS_CSI     = 3'd2;
  localparam logic [2:0] PS_OSC     = 3'd3;
  localparam logic [2:0] PS_OSC_ESC = 3'd4;

  logic [2:0]  ps_r, ps_nxt;
  logic [15:0] num_r, num_nxt;
  logic        extra_r, extra_nxt;
  logic [19:0] num_x10;
  logic [7:0]  c;

  assign c       = item.byte_in;
  assign num_x10 = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0} + {16'd0, c[3:0]};

  always_comb begin
    ps_nxt    = ps_r;
    num_nxt   = num_r;
    extra_nxt = extra_r;
    push      = 1'b0;
    cmd.op    = OP_PUT;
    cmd.ch    = c;
    cmd.num   = num_r;
    if (acc) begin
      if (item.end_of_stream) begin
        push   = 1'b1;
        cmd.op = OP_FLUSH;
        ps_nxt = PS_NORMAL;
      end else begin
        case (ps_r)
          PS_ESC: begin
            if (c == "[") begin
              ps_nxt    = PS_CSI;
              num_nxt   = 16'd0;
              extra_nxt = 1'b0;
            end else if (c == "]") begin
              ps_nxt = PS_OSC;
            end else if (c < 8'h20 || c > 8'h2f) begin
              ps_nxt = PS_NORMAL;
            end
          end
          PS_CSI: begin
            if (c inside {["0":"9"]} && !extra_r) begin
              num_nxt = (num_x10 > 20'd65535) ? 16'hffff : num_x10[15:0];
            end else if (c == ";") begin
              extra_nxt = 1'b1;
            end else if (c inside {[8'h40:8'h7e]}) begin
              ps_nxt = PS_NORMAL;
              push   = 1'b1;
              case (c)
                "K":     cmd.op = OP_ERASE;
                "C":     cmd.op = OP_RIGHT;
                "D":     cmd.op = OP_LEFT;
                "G":     cmd.op = OP_COL;
                "P":     cmd.op = OP_DEL;
                "@":     cmd.op = OP_INS;
                "X":     cmd.op = OP_BLANK;
                default: push = 1'b0;
              endcase
            end
          end
          PS_OSC: begin
            if (c == CH_BEL) ps_nxt = PS_NORMAL;
            else if (c == CH_ESC) ps_nxt = PS_OSC_ESC;
          end
          PS_OSC_ESC: begin
            if (c == "\\") ps_nxt = PS_NORMAL;
            else if (c != CH_ESC) ps_nxt = PS_OSC;
          end
          default: begin
            ps_nxt = PS_NORMAL;
            if (c == CH_ESC) begin
              ps_nxt = PS_ESC;
            end else if (c == 8'h0a) begin
              push = 1'b1; cmd.op = OP_NL;
            end else if (c == 8'h0d) begin
              push = 1'b1; cmd.op = OP_CR;
            end else if (c == 8'h08) begin
              push = 1'b1; cmd.op = OP_BS;
            end else if (c == 8'h09) begin
              push = 1'b1; cmd.op = OP_PUT;
            end else if (c < 8'h20 || c == CH_DEL) begin
              push = 1'b0;
            end else begin
              push = 1'b1; cmd.op = OP_PUT;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r    <= PS_NORMAL;
      num_r   <= 16'd0;
      extra_r <= 1'b0;
    end else begin
      ps_r    <= ps_nxt;
      num_r   <= num_nxt;
      extra_r <= extra_nxt;
    end
  end

endmodule

[design/ansi_ela_queue.sv]
// two-entry command queue between parser and line editor
module ansi_ela_queue import ansi_ela_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      wdata,
  input  logic      pop,
  output cmd_t      rdata,
  output q_status_t status
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign rdata        = ent_r[rp_r];
  assign status.full  = (cnt_r == 2'd2);
  assign status.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/ansi_ela_back.sv]
// line editor: line store, cursor, edits and line emission
module ansi_ela_back import ansi_ela_pkg::*; #(
  parameter int LINE_CAP = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       cmd,
  output logic       pop,
  input  logic [7:0] tag,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int DEPTH  = LINE_CAP + MARK_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] WRAP_AT = LEN_W'(LINE_CAP - MARK_LEN - 1);
  localparam logic [LEN_W-1:0] MAX_INS = LEN_W'(LINE_CAP - 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MARK  = 4'd1;
  localparam logic [3:0] ST_ERD   = 4'd2;
  localparam logic [3:0] ST_EWAIT = 4'd3;
  localparam logic [3:0] ST_EMPTY = 4'd4;
  localparam logic [3:0] ST_DRD   = 4'd5;
  localparam logic [3:0] ST_DWR   = 4'd6;
  localparam logic [3:0] ST_IRD   = 4'd7;
  localparam logic [3:0] ST_IWR   = 4'd8;
  localparam logic [3:0] ST_FILL  = 4'd9;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;
  logic [LEN_W-1:0] rd_addr;
  logic       we;
  logic [LEN_W-1:0] wa;
  logic [7:0] wd;

  logic [3:0] st_r, st_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, cur_r, cur_nxt;
  logic [LEN_W-1:0] src_r, src_nxt, dst_r, dst_nxt, cnt_r, cnt_nxt;
  logic [LEN_W-1:0] fcnt_r, fcnt_nxt;
  logic [3:0] mi_r, mi_nxt;
  logic [7:0] ch_r, ch_nxt;
  logic       pend_r, pend_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;

  logic [15:0] nn;
  logic [LEN_W-1:0] tail, room, n_tail, n_room;
  logic [16:0] cur_plus;
  logic        out_free;

  assign nn       = (cmd.num == 16'd0) ? 16'd1 : cmd.num;
  assign tail     = len_r - cur_r;
  assign room     = (len_r < MAX_INS) ? MAX_INS - len_r : '0;
  assign n_tail   = (nn > {{(16-LEN_W){1'b0}}, tail}) ? tail : nn[LEN_W-1:0];
  assign n_room   = (nn > {{(16-LEN_W){1'b0}}, room}) ? room : nn[LEN_W-1:0];
  assign cur_plus = {{(17-LEN_W){1'b0}}, cur_r} + {1'b0, nn};
  assign out_free = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    st_nxt   = st_r;
    len_nxt  = len_r;
    cur_nxt  = cur_r;
    src_nxt  = src_r;
    dst_nxt  = dst_r;
    cnt_nxt  = cnt_r;
    fcnt_nxt = fcnt_r;
    mi_nxt   = mi_r;
    ch_nxt   = ch_r;
    pend_nxt = pend_r;
    ov_nxt   = ov_r && out_stall;
    od_nxt   = od_r;
    pop      = 1'b0;
    we       = 1'b0;
    wa       = cur_r;
    wd       = cmd.ch;
    rd_addr  = src_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (cmd.op)
            OP_PUT: begin
              if (cur_r >= WRAP_AT) begin
                ch_nxt   = cmd.ch;
                pend_nxt = 1'b1;
                mi_nxt   = 4'd0;
                st_nxt   = ST_MARK;
              end else begin
                we      = 1'b1;
                cur_nxt = cur_r + 1'b1;
                if (cur_r + 1'b1 > len_r) len_nxt = cur_r + 1'b1;
              end
            end
            OP_NL: begin
              pend_nxt = 1'b0;
              src_nxt  = '0;
              st_nxt   = (len_r == '0) ? ST_EMPTY : ST_ERD;
            end
            OP_FLUSH: begin
              pend_nxt = 1'b0;
              src_nxt  = '0;
              if (len_r != '0) st_nxt = ST_ERD;
            end
            OP_CR: cur_nxt = '0;
            OP_BS: if (cur_r != '0) cur_nxt = cur_r - 1'b1;
            OP_ERASE: len_nxt = cur_r;
            OP_RIGHT: cur_nxt = (cur_plus > {{(17-LEN_W){1'b0}}, len_r}) ? len_r
                                : cur_plus[LEN_W-1:0];
            OP_LEFT: cur_nxt = (nn > {{(16-LEN_W){1'b0}}, cur_r}) ? '0
                               : cur_r - nn[LEN_W-1:0];
            OP_COL: cur_nxt = (nn - 16'd1 > {{(16-LEN_W){1'b0}}, len_r}) ? len_r
                              : LEN_W'(nn - 16'd1);
            OP_DEL: begin
              len_nxt = len_r - n_tail;
              src_nxt = cur_r + n_tail;
              dst_nxt = cur_r;
              cnt_nxt = tail - n_tail;
              if (n_tail != '0 && tail != n_tail) st_nxt = ST_DRD;
            end
            OP_INS: begin
              len_nxt  = len_r + n_room;
              src_nxt  = len_r - 1'b1;
              dst_nxt  = len_r - 1'b1 + n_room;
              cnt_nxt  = tail;
              fcnt_nxt = n_room;
              if (n_room != '0) st_nxt = (tail != '0) ? ST_IRD : ST_FILL;
              if (tail == '0) dst_nxt = cur_r;
            end
            OP_BLANK: begin
              dst_nxt  = cur_r;
              fcnt_nxt = n_tail;
              if (n_tail != '0) st_nxt = ST_FILL;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        we = 1'b1;
        wa = len_r + {2'b00, mi_r};
        wd = mark_char(mi_r);
        mi_nxt = mi_r + 4'd1;
        if (mi_r == 4'(MARK_LEN - 1)) begin
          len_nxt = len_r + LEN_W'(MARK_LEN);
          src_nxt = '0;
          st_nxt  = ST_ERD;
        end
      end
      ST_ERD: st_nxt = ST_EWAIT;
      ST_EWAIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.line_char    = rd_data_r;
          od_nxt.empty_line   = 1'b0;
          od_nxt.last_of_line = (src_r + 1'b1 == len_r);
          od_nxt.tag          = tag;
          src_nxt = src_r + 1'b1;
          if (src_r + 1'b1 == len_r) begin
            st_nxt = ST_IDLE;
            // a wrapped character opens the next line
            if (pend_r) begin
              we      = 1'b1;
              wa      = '0;
              wd      = ch_r;
              cur_nxt = LEN_W'(1);
              len_nxt = LEN_W'(1);
            end else begin
              cur_nxt = '0;
              len_nxt = '0;
            end
            pend_nxt = 1'b0;
          end else begin
            st_nxt = ST_ERD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt.line_char    = 8'd0;
          od_nxt.empty_line   = 1'b1;
          od_nxt.last_of_line = 1'b1;
          od_nxt.tag          = tag;
          cur_nxt = '0;
          st_nxt  = ST_IDLE;
        end
      end
      ST_DRD: st_nxt = ST_DWR;
      ST_DWR: begin
        we = 1'b1; wa = dst_r; wd = rd_data_r;
        src_nxt = src_r + 1'b1;
        dst_nxt = dst_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        st_nxt  = (cnt_r == LEN_W'(1)) ? ST_IDLE : ST_DRD;
      end
      ST_IRD: st_nxt = ST_IWR;
      ST_IWR: begin
        we = 1'b1; wa = dst_r; wd = rd_data_r;
        src_nxt = src_r - 1'b1;
        dst_nxt = dst_r - 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == LEN_W'(1)) begin
          dst_nxt = cur_r;
          st_nxt  = ST_FILL;
        end else begin
          st_nxt = ST_IRD;
        end
      end
      ST_FILL: begin
        we = 1'b1; wa = dst_r; wd = CH_SP;
        dst_nxt  = dst_r + 1'b1;
        fcnt_nxt = fcnt_r - 1'b1;
        if (fcnt_r == LEN_W'(1)) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa[ADDR_W-1:0]] <= wd;
    rd_data_r <= mem[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    cnt_r  <= cnt_nxt;
    fcnt_r <= fcnt_nxt;
    mi_r   <= mi_nxt;
    ch_r   <= ch_nxt;
    od_r   <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      len_r  <= '0;
      cur_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      len_r  <= len_nxt;
      cur_r  <= cur_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

[design/ansi_escape_line_assembler_core.sv]
// top level of the escape line assembler
// Terminal byte stream in, assembled lines out, one character per transfer.
// Input channel in_valid/in_stall carries one byte (or an end-of-stream flag)
// per transfer. The parser takes a byte every cycle while its two-entry
// command queue has room; in_stall rises when the queue is full.
// Output channel out_valid/out_stall carries one line character per transfer
// with last_of_line on the final one; an empty line gives one transfer with
// empty_line set. Each character is read from the line store (ST_ERD) and then
// emitted (ST_EWAIT). A printable byte is one editor write; a wrap first writes
// the ten-character marker before emission; delete and insert move each
// character by a read state and a write state; blanking writes one per cycle.
// cfg_we writes cfg_wdata as the tag, copied into every result; write only while idle.
// Synchronous active-low reset empties the line, clears the parser and
// the queue; the line store itself is not cleared.
// While out_stall is high a valid result holds, the editor waits at its next
// emission, the queue fills and then in_stall rises.
module ansi_escape_line_assembler_core import ansi_ela_pkg::*; #(
  parameter int LINE_CAP = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  `include "assert_macros.svh"

  logic      in_acc, push, pop;
  cmd_t      f_cmd, q_cmd;
  q_status_t q_st;
  logic [7:0] tag_r;

  assign in_stall = q_st.full;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) tag_r <= 8'd0;
    else if (cfg_we) tag_r <= cfg_wdata;
  end

  ansi_ela_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(in_acc), .item(in_data),
    .push(push), .cmd(f_cmd)
  );

  ansi_ela_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(f_cmd),
    .pop(pop), .rdata(q_cmd), .status(q_st)
  );

  ansi_ela_back #(.LINE_CAP(LINE_CAP)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_st.empty), .cmd(q_cmd), .pop(pop),
    .tag(tag_r), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  `CHK_NOW(a_no_push_full, push, !q_st.full, "command pushed into full queue")
  `CHK_NOW(a_no_pop_empty, pop, !q_st.empty, "command popped from empty queue")
  `CHK_NOW(a_empty_is_last, out_valid && out_data.empty_line, out_data.last_of_line,
           "empty line result without last mark")
  `CHK_NEXT(a_queue_fill, !in_stall && in_valid && push && !pop && !q_st.empty, in_stall,
            "queue did not report full")

endmodule
